[design/pfit_pkg.sv]
// Package: shared types and constants of the timestamp frame index tracker.
`timescale 1ns / 1ps

package pfit_pkg;

	localparam int PtsW    = 64;
	localparam int IndexW  = 32;
	localparam int CfgW    = 4;
	localparam int CfgIdxW = 2;
	localparam int RunW    = 4;
	localparam int DivSteps = PtsW;
	localparam int DivCntW  = $clog2(DivSteps);

	localparam logic [CfgW-1:0] WarmupReset = 4'd3;
	localparam logic [CfgW-1:0] StableReset = 4'd3;
	localparam logic [RunW-1:0] RunMax      = 4'd15;

	// Register map of the configuration channel
	typedef enum logic [CfgIdxW-1:0] {
		REG_WARMUP = 2'd0,
		REG_STABLE = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LEARN,
		ST_LIMIT,
		ST_CMP,
		ST_DIV,
		ST_ACC,
		ST_DONE
	} state_t;

endpackage

[design/pts_frame_index_tracker.sv]
// Top level: rebuilds a video frame index from packet timestamps.
`timescale 1ns / 1ps

// Takes one 64-bit signed timestamp per input beat and returns one beat with the
// reconstructed 32-bit frame index (tdata) and a gap flag (tuser). An item ends
// after the check for a zero timestamp, a latch or a warm-up packet, after the
// learning step for a step that is not positive, after the limit for a zero
// duration and after the compare when a learned step advances the index by one.
// A timestamp gap of more than 1.5 frame durations goes on to the divider:
// the gap length in frames comes from a restoring divider that produces one
// quotient bit per cycle over all 64 dividend bits. One item is in work at a
// time; the next is accepted as soon as the previous result sits in the output
// register, even if the sink has not taken it yet. Configuration registers
// (0: warm-up frames, 1: stable repeats) are always ready and are to be written
// only while the block is idle.
module pts_frame_index_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfit_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pfit_pkg::CfgW-1:0]      cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pfit_pkg::PtsW-1:0]      s_tdata,   // [63:0] pts
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pfit_pkg::IndexW-1:0]    m_tdata,   // [31:0] frame_index
	output logic                           m_tuser    // [0] gap_jump
);

	import pfit_pkg::*;

	state_t               state_q, state_d;
	logic [CfgW-1:0]      warmup_q, stable_q;
	logic [PtsW-1:0]      pts_q, last_pts_q, step_q, measured_q, active_q, limit_q;
	logic [IndexW-1:0]    count_q;
	logic [RunW-1:0]      run_q;
	logic                 gap_q;
	logic [PtsW-1:0]      rem_q, dvd_q;
	logic [IndexW-1:0]    quo_q;
	logic [DivCntW-1:0]   div_cnt_q;

	logic                 out_free;
	logic                 last_pos, step_pos, step_eq, adopt;
	logic [RunW-1:0]      run_d;
	logic [PtsW-1:0]      measured_d;
	logic [PtsW-1:0]      rem_sh;
	logic                 rem_ge;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_tvalid || m_tready;

	assign last_pos = (last_pts_q != '0) && !last_pts_q[PtsW-1];
	assign step_pos = (step_q != '0) && !step_q[PtsW-1];
	assign step_eq  = (step_q == measured_q);

	// Learning: run length of equal steps and candidate duration
	always_comb begin
		if (step_eq) begin
			run_d      = (run_q == RunMax) ? run_q : run_q + RunW'(1);
			measured_d = measured_q;
		end else begin
			run_d      = '0;
			measured_d = step_pos ? step_q : measured_q;
		end
		adopt = active_q[PtsW-1] || (run_d > stable_q);
	end

	// Divider: one quotient bit per cycle
	assign rem_sh = {rem_q[PtsW-2:0], dvd_q[PtsW-1]};
	assign rem_ge = (rem_sh >= active_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= WarmupReset;
			stable_q <= StableReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WARMUP: warmup_q <= cfg_data;
				REG_STABLE: stable_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (pts_q == '0)                      state_d = ST_DONE;
				else if (!last_pos)                            state_d = ST_DONE;
				else if (count_q < {{(IndexW-CfgW){1'b0}}, warmup_q}) state_d = ST_DONE;
				else                                           state_d = ST_LEARN;
			end
			ST_LEARN: state_d = step_pos ? ST_LIMIT : ST_DONE;
			ST_LIMIT: state_d = (active_q == '0) ? ST_DONE : ST_CMP;
			ST_CMP:   state_d = (step_q > limit_q) ? ST_DIV : ST_DONE;
			ST_DIV: begin
				if (div_cnt_q == DivCntW'(DivSteps-1)) state_d = ST_ACC;
			end
			ST_ACC:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pts_q <= '0;
			count_q    <= '0;
			measured_q <= '0;
			run_q      <= '0;
			active_q   <= '1;
			gap_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: gap_q <= 1'b0;
				ST_CHECK: begin
					priority if (pts_q == '0) begin
						count_q <= count_q + IndexW'(1);
					end else if (!last_pos) begin
						last_pts_q <= pts_q;
						count_q    <= IndexW'(1);
					end else if (count_q < {{(IndexW-CfgW){1'b0}}, warmup_q}) begin
						last_pts_q <= pts_q;
						count_q    <= count_q + IndexW'(1);
					end
				end
				ST_LEARN: begin
					run_q      <= run_d;
					measured_q <= measured_d;
					if (adopt) active_q <= measured_d;
				end
				ST_LIMIT: begin
					// zero duration counts as one frame
					if (active_q == '0) begin
						last_pts_q <= pts_q;
						count_q    <= count_q + IndexW'(1);
					end
				end
				ST_CMP: begin
					if (!(step_q > limit_q)) begin
						last_pts_q <= pts_q;
						count_q    <= count_q + IndexW'(1);
					end
				end
				ST_ACC: begin
					last_pts_q <= pts_q;
					count_q    <= count_q + quo_q;
					gap_q      <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers: timestamp, step, limit and divider
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) pts_q <= s_tdata;
		if (state_q == ST_CHECK) step_q <= pts_q - last_pts_q;
		if (state_q == ST_LIMIT) limit_q <= active_q + (active_q >> 1);
		if (state_q == ST_CMP) begin
			rem_q     <= '0;
			dvd_q     <= step_q;
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q     <= rem_ge ? rem_sh - active_q : rem_sh;
			dvd_q     <= {dvd_q[PtsW-2:0], 1'b0};
			quo_q     <= {quo_q[IndexW-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + DivCntW'(1);
		end
	end

	// Output register: hold the beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= count_q;
			m_tuser <= gap_q;
		end
	end

`ifndef SYNTH
	// Divider only runs with a learned, positive duration
	a_div_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (active_q != '0) && !active_q[PtsW-1])
		else $error("divider running with non-positive duration");

	// Partial remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < active_q)
		else $error("divider remainder out of range");

	// Learned step never holds a negative value
	a_meas_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!measured_q[PtsW-1])
		else $error("measured step negative");

	// A finished item reaches the output register on handoff
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> m_tvalid && state_q == ST_IDLE)
		else $error("result not handed to output register");

	// Gap flag only set after a divide
	a_gap_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gap_q) |-> $past(state_q) == ST_ACC)
		else $error("gap flag set without a divide");
`endif

endmodule
